@@ rtl/dsc_pkg.sv @@
// Package for the deadlock safety check block: sizes, field widths,
// request and register codes, sequencer state type. No dependencies.
package dsc_pkg;

  localparam int MAX_PROCS  = 16;
  localparam int MAX_RES    = 16;
  localparam int VALUE_BITS = 16;

  // fixed port widths
  localparam int REQ_W     = 2;
  localparam int IDX_W     = 4;
  localparam int FIELD_W   = 16;
  localparam int CNT_OUT_W = 5;
  localparam int MASK_W    = 16;
  localparam int CFG_IDX_W = 1;
  localparam int CFG_W     = 5;

  // derived sizes
  localparam int PROC_W  = (MAX_PROCS > 1) ? $clog2(MAX_PROCS) : 1;
  localparam int RES_W   = (MAX_RES > 1) ? $clog2(MAX_RES) : 1;
  localparam int PCNT_W  = $clog2(MAX_PROCS + 1);
  localparam int RCNT_W  = $clog2(MAX_RES + 1);
  localparam int ADDR_W  = PROC_W + RES_W;
  localparam int TBL_DEPTH = 2 ** ADDR_W;

  // request codes
  localparam logic [REQ_W-1:0] REQ_AVAIL = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ALLOC = 2'd1;
  localparam logic [REQ_W-1:0] REQ_CHECK = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_NUM_PROCESSES = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_NUM_RESOURCES = 1'd1;

  typedef enum logic [6:0] {
    ST_IDLE    = 7'b0000001,
    ST_SEL     = 7'b0000010,
    ST_RD      = 7'b0000100,
    ST_CMP     = 7'b0001000,
    ST_REL_RD  = 7'b0010000,
    ST_REL_ADD = 7'b0100000,
    ST_DONE    = 7'b1000000
  } state_t;

endpackage

@@ rtl/dsc_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// Standalone; no package dependency.
module dsc_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

@@ rtl/deadlock_safety_check_top.sv @@
// Deadlock safety check top level: load stores, sequencer, shared compare/add.
// Depends on dsc_pkg and dsc_ram.
//
//  channel | ports                                   | direction
//  --------+-----------------------------------------+----------
//  in      | in_valid/in_ready, in_req_type..value   | in
//  out     | out_valid/out_ready, deadlocked/count.. | out
//  cfg     | cfg_wr_en, cfg_index, cfg_wdata         | in
//
// Load words write the table or the available vector. A check word walks the
// table one entry at a time through the shared compare/add logic, each entry
// a RAM read state followed by a compare or add state.
// in_ready is low while a check runs; a finished result may wait in the output
// register while new load words are taken. Reset clears control state and the
// work vector; the tables and available vector are undefined until loaded.
module deadlock_safety_check_top (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [dsc_pkg::REQ_W-1:0]      in_req_type,
  input  logic [dsc_pkg::IDX_W-1:0]      in_proc_index,
  input  logic [dsc_pkg::IDX_W-1:0]      in_res_index,
  input  logic [dsc_pkg::FIELD_W-1:0]    in_avail_value,
  input  logic [dsc_pkg::FIELD_W-1:0]    in_alloc_value,
  input  logic [dsc_pkg::FIELD_W-1:0]    in_need_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_deadlocked,
  output logic [dsc_pkg::CNT_OUT_W-1:0]  out_unfinished_count,
  output logic [dsc_pkg::MASK_W-1:0]     out_finished_mask,
  input  logic                           cfg_wr_en,
  input  logic [dsc_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [dsc_pkg::CFG_W-1:0]      cfg_wdata
);

  import dsc_pkg::*;

  state_t state_r, state_nxt;

  logic [CFG_W-1:0]      num_proc_r, num_res_r;
  logic [PCNT_W-1:0]     np_c;
  logic [RCNT_W-1:0]     nr_c;

  logic [VALUE_BITS-1:0] avail_r [MAX_RES];
  logic [VALUE_BITS-1:0] work_r  [MAX_RES];
  logic [VALUE_BITS-1:0] work_nxt;
  logic                  work_we;

  logic [MAX_PROCS-1:0]  fin_r, fin_nxt;
  logic [PCNT_W-1:0]     done_cnt_r, done_cnt_nxt;
  logic [PCNT_W-1:0]     p_r, p_nxt;
  logic [RCNT_W-1:0]     r_r, r_nxt;

  logic                  accept;
  logic                  tbl_we;
  logic [ADDR_W-1:0]     tbl_waddr, tbl_raddr;
  logic [2*VALUE_BITS-1:0] tbl_wdata, tbl_rdata;
  logic [VALUE_BITS-1:0] need_rd, alloc_rd, work_cur;
  logic [VALUE_BITS:0]   sum;
  logic                  out_load;
  logic [PCNT_W-1:0]     unfinished;
  logic [MASK_W-1:0]     mask_c;

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == ST_IDLE);

  // clamp register values to the configured maximum
  assign np_c = (32'(num_proc_r) > MAX_PROCS) ? PCNT_W'(MAX_PROCS) : PCNT_W'(num_proc_r);
  assign nr_c = (32'(num_res_r) > MAX_RES) ? RCNT_W'(MAX_RES) : RCNT_W'(num_res_r);

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_proc_r <= CFG_W'(16);
      num_res_r  <= CFG_W'(16);
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_NUM_PROCESSES: num_proc_r <= cfg_wdata;
        REG_NUM_RESOURCES: num_res_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  // alloc and need share one row: {alloc, need}
  assign tbl_we    = accept && (in_req_type == REQ_ALLOC) &&
                     (32'(in_proc_index) < MAX_PROCS) && (32'(in_res_index) < MAX_RES);
  assign tbl_waddr = {PROC_W'(in_proc_index), RES_W'(in_res_index)};
  assign tbl_wdata = {VALUE_BITS'(in_alloc_value), VALUE_BITS'(in_need_value)};
  assign tbl_raddr = {p_r[PROC_W-1:0], r_r[RES_W-1:0]};

  dsc_ram #(
    .WIDTH (2*VALUE_BITS),
    .DEPTH (TBL_DEPTH)
  ) u_tbl (
    .clk     (clk),
    .wr_en   (tbl_we),
    .wr_addr (tbl_waddr),
    .wr_data (tbl_wdata),
    .rd_addr (tbl_raddr),
    .rd_data (tbl_rdata)
  );

  assign need_rd  = tbl_rdata[VALUE_BITS-1:0];
  assign alloc_rd = tbl_rdata[2*VALUE_BITS-1:VALUE_BITS];
  assign work_cur = work_r[r_r[RES_W-1:0]];

  // shared saturating adder
  assign sum      = {1'b0, work_cur} + {1'b0, alloc_rd};
  assign work_nxt = sum[VALUE_BITS] ? {VALUE_BITS{1'b1}} : sum[VALUE_BITS-1:0];

  always_ff @(posedge clk) begin
    if (accept && (in_req_type == REQ_AVAIL) && (32'(in_res_index) < MAX_RES)) begin
      avail_r[RES_W'(in_res_index)] <= VALUE_BITS'(in_avail_value);
    end
  end

  // work vector: bulk copy at check start, one entry updated per add step
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_RES; i++) begin
        work_r[i] <= '0;
      end
    end else if (accept && (in_req_type == REQ_CHECK)) begin
      for (int i = 0; i < MAX_RES; i++) begin
        work_r[i] <= avail_r[i];
      end
    end else if (work_we) begin
      work_r[r_r[RES_W-1:0]] <= work_nxt;
    end
  end

  always_comb begin
    state_nxt    = state_r;
    p_nxt        = p_r;
    r_nxt        = r_r;
    fin_nxt      = fin_r;
    done_cnt_nxt = done_cnt_r;
    work_we      = 1'b0;
    out_load     = 1'b0;
    unique case (state_r)
      ST_IDLE: begin
        if (accept && (in_req_type == REQ_CHECK)) begin
          fin_nxt      = '0;
          done_cnt_nxt = '0;
          p_nxt        = '0;
          r_nxt        = '0;
          state_nxt    = ST_SEL;
        end
      end
      ST_SEL: begin
        if (p_r >= np_c) begin
          state_nxt = ST_DONE;
        end else if (fin_r[p_r[PROC_W-1:0]]) begin
          p_nxt = p_r + 1'b1;
        end else begin
          r_nxt     = '0;
          state_nxt = ST_RD;
        end
      end
      ST_RD: begin
        // need row read issued here; all resources passed means it fits
        if (r_r >= nr_c) begin
          r_nxt     = '0;
          state_nxt = ST_REL_RD;
        end else begin
          state_nxt = ST_CMP;
        end
      end
      ST_CMP: begin
        if (need_rd > work_cur) begin
          p_nxt     = p_r + 1'b1;
          state_nxt = ST_SEL;
        end else begin
          r_nxt     = r_r + 1'b1;
          state_nxt = ST_RD;
        end
      end
      ST_REL_RD: begin
        if (r_r >= nr_c) begin
          fin_nxt[p_r[PROC_W-1:0]] = 1'b1;
          done_cnt_nxt = done_cnt_r + 1'b1;
          p_nxt        = '0;
          state_nxt    = ST_SEL;
        end else begin
          state_nxt = ST_REL_ADD;
        end
      end
      ST_REL_ADD: begin
        work_we   = 1'b1;
        r_nxt     = r_r + 1'b1;
        state_nxt = ST_REL_RD;
      end
      ST_DONE: begin
        if (!out_valid || out_ready) begin
          out_load  = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_IDLE;
      p_r        <= '0;
      r_r        <= '0;
      fin_r      <= '0;
      done_cnt_r <= '0;
    end else begin
      state_r    <= state_nxt;
      p_r        <= p_nxt;
      r_r        <= r_nxt;
      fin_r      <= fin_nxt;
      done_cnt_r <= done_cnt_nxt;
    end
  end

  assign unfinished = np_c - done_cnt_r;
  assign mask_c     = MASK_W'(fin_r);

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_deadlocked       <= (unfinished != '0);
      out_unfinished_count <= CNT_OUT_W'(unfinished);
      out_finished_mask    <= mask_c;
    end
  end

  // a result word only appears after the sequencer reaches its final state
  a_out_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid) |-> $past(state_r == ST_DONE))
    else $error("result word without completed check");

  // finish counter tracks the finished flags
  a_cnt_matches: assert property (@(posedge clk) disable iff (!rst_n)
    $countones(fin_r) == 32'(done_cnt_r))
    else $error("finish count out of step with flags");

  // compare only happens on an in-range resource of a taking-part process
  a_cmp_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CMP) |-> ((r_r < nr_c) && (p_r < np_c)))
    else $error("compare step out of range");

  // a finished process is never credited again within one check
  a_no_refinish: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_REL_RD) |-> !fin_r[p_r[PROC_W-1:0]])
    else $error("release of an already finished process");

endmodule
